>>> rtl/core/line_plane_clip_point_defines.svh
// assertion macros shared by the line/plane clip datapath
// used by lpc_div and lpc_interp, expects aclk and aresetn in scope
`ifndef LINE_PLANE_CLIP_POINT_DEFINES_SVH
`define LINE_PLANE_CLIP_POINT_DEFINES_SVH

// same-cycle implication, off while reset is held
`define LPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define LPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lpc_pkg.sv
// shared types and constants of the line/plane clip block
// no dependencies; imported by every module of the block
package lpc_pkg;

    // configuration register
    localparam int THR_W = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd66;

    // register file address decode
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;

    // per-item status traveling down the pipeline
    typedef struct packed {
        logic par;  // denominator inside the parallel band, t forced to one half
        logic neg;  // quotient is negative
        logic ovf;  // quotient magnitude does not fit the coordinate width
    } lpc_flags_t;

endpackage

>>> rtl/core/lpc_front.sv
// front end: delta, dot products, band test and divider setup, five stages
// depends on lpc_pkg
module lpc_front import lpc_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0][W-1:0]       in_start,
    input  logic [2:0][W-1:0]       in_end,
    input  logic [2:0][W-1:0]       in_normal,
    input  logic [W-1:0]            in_offset,
    input  logic [THR_W-1:0]        thr,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0][W-1:0]       out_start,
    output logic [2:0][W:0]         out_delta,
    output lpc_flags_t              out_flags,
    output logic [2*W+2:0]          out_dmag,
    output logic [2*W+2:0]          out_rem,
    output logic [W-1:0]            out_lq
);

    localparam int NS   = 5;
    localparam int VW   = W + 1;
    localparam int PS_W = 2 * W;
    localparam int PV_W = 2 * W + 1;
    localparam int DW   = 2 * W + 3;
    localparam int NW   = (((W + F) > (2 * W)) ? (W + F) : (2 * W)) + 3;
    localparam int HW   = NW + F - W;
    localparam int CW   = (HW > DW) ? HW : DW;
    localparam int CMPW = ((DW > (THR_W + F)) ? DW : (THR_W + F)) + 1;

    logic [NS-1:0]             vld_reg;
    logic [NS:0]               rdy;
    logic [NS-1:0][2:0][W-1:0] s_pipe_reg;
    logic [NS-1:0][2:0][VW-1:0] v_pipe_reg;

    logic [2:0][W-1:0]    n0_reg;
    logic [W-1:0]         d0_reg;
    logic [2:0][PS_W-1:0] ps1_reg;
    logic [2:0][PV_W-1:0] pv1_reg;
    logic [W+F-1:0]       dsh1_reg;
    logic [NW-1:0]        sum2_reg;
    logic [DW-1:0]        den2_reg;
    logic [NW-1:0]        nmag3_reg;
    logic [DW-1:0]        dmag3_reg;
    lpc_flags_t           flags3_reg;
    logic [DW-1:0]        dmag4_reg;
    logic [DW-1:0]        rem4_reg;
    logic [W-1:0]         lq4_reg;
    lpc_flags_t           flags4_reg;

    logic [NW-1:0]        sum_next;
    logic [DW-1:0]        den_next;
    logic [NW-1:0]        nmag_next;
    logic [DW-1:0]        dmag_next;
    lpc_flags_t           flags3_next;
    logic signed [CMPW-1:0] den_cmp;
    logic signed [CMPW-1:0] band_cmp;
    logic                 numneg;
    logic [NW+F-1:0]      dvd;
    logic [CW-1:0]        hi_ext;
    logic [CW-1:0]        dmag_ext;
    lpc_flags_t           flags4_next;

    // stall chain: a stage loads when empty or when its content moves on
    assign rdy[NS] = out_ready;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end
    assign in_ready = rdy[0];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // start point and delta ride along every stage
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                s_pipe_reg[0][i] <= in_start[i];
                v_pipe_reg[0][i] <= VW'($signed(in_end[i])) - VW'($signed(in_start[i]));
            end
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
                s_pipe_reg[k] <= s_pipe_reg[k-1];
                v_pipe_reg[k] <= v_pipe_reg[k-1];
            end
        end
    end

    // stage 0: capture normal and offset
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            n0_reg <= in_normal;
            d0_reg <= in_offset;
        end
    end

    // stage 1: full products n.s and n.v, offset scaled to product format
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                ps1_reg[i] <= PS_W'($signed(n0_reg[i])) * PS_W'($signed(s_pipe_reg[0][i]));
                pv1_reg[i] <= PV_W'($signed(n0_reg[i])) * PV_W'($signed(v_pipe_reg[0][i]));
            end
            dsh1_reg <= {d0_reg, {F{1'b0}}};
        end
    end

    // stage 2: plane distance of start point and denominator
    assign sum_next = NW'($signed(dsh1_reg)) + NW'($signed(ps1_reg[0]))
                    + NW'($signed(ps1_reg[1])) + NW'($signed(ps1_reg[2]));
    assign den_next = DW'($signed(pv1_reg[0])) + DW'($signed(pv1_reg[1]))
                    + DW'($signed(pv1_reg[2]));

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            sum2_reg <= sum_next;
            den2_reg <= den_next;
        end
    end

    // stage 3: magnitudes, quotient sign, parallel band
    always_comb begin
        den_cmp   = CMPW'($signed(den2_reg));
        band_cmp  = CMPW'({thr, {F{1'b0}}});
        // numerator is minus the distance sum
        numneg    = !sum2_reg[NW-1] && (sum2_reg != '0);
        nmag_next = sum2_reg[NW-1] ? -sum2_reg : sum2_reg;
        dmag_next = den2_reg[DW-1] ? -den2_reg : den2_reg;
        flags3_next.par = ((den_cmp < band_cmp) && (den_cmp > -band_cmp))
                          || (den2_reg == '0);
        flags3_next.neg = numneg ^ den2_reg[DW-1];
        flags3_next.ovf = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            nmag3_reg  <= nmag_next;
            dmag3_reg  <= dmag_next;
            flags3_reg <= flags3_next;
        end
    end

    // stage 4: quotient range check and initial partial remainder
    always_comb begin
        dvd      = {nmag3_reg, {F{1'b0}}};
        hi_ext   = CW'(dvd[NW+F-1:W]);
        dmag_ext = CW'(dmag3_reg);
        flags4_next     = flags3_reg;
        flags4_next.ovf = (hi_ext >= dmag_ext);
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            dmag4_reg  <= dmag3_reg;
            rem4_reg   <= hi_ext[DW-1:0];
            lq4_reg    <= dvd[W-1:0];
            flags4_reg <= flags4_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_start = s_pipe_reg[NS-1];
    assign out_delta = v_pipe_reg[NS-1];
    assign out_flags = flags4_reg;
    assign out_dmag  = dmag4_reg;
    assign out_rem   = rem4_reg;
    assign out_lq    = lq4_reg;

endmodule

>>> rtl/core/lpc_div.sv
// pipelined restoring divider, one quotient bit per stage, W stages
// depends on lpc_pkg and line_plane_clip_point_defines.svh
`include "line_plane_clip_point_defines.svh"
module lpc_div import lpc_pkg::*; #(
    parameter int W = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0][W-1:0]       in_start,
    input  logic [2:0][W:0]         in_delta,
    input  lpc_flags_t              in_flags,
    input  logic [2*W+2:0]          in_dmag,
    input  logic [2*W+2:0]          in_rem,
    input  logic [W-1:0]            in_lq,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0][W-1:0]       out_start,
    output logic [2:0][W:0]         out_delta,
    output lpc_flags_t              out_flags,
    output logic [W-1:0]            out_quot
);

    localparam int VW = W + 1;
    localparam int DW = 2 * W + 3;

    logic                  vld_reg   [W];
    logic                  rdy       [W+1];
    logic [DW-1:0]         rem_reg   [W];
    logic [DW-1:0]         dmag_reg  [W];
    logic [W-1:0]          lq_reg    [W];
    lpc_flags_t            flags_reg [W];
    logic [2:0][W-1:0]     s_reg     [W];
    logic [2:0][VW-1:0]    v_reg     [W];

    assign rdy[W]   = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < W; k++) begin : g_step
        logic               src_vld;
        logic [DW-1:0]      src_rem;
        logic [DW-1:0]      src_dmag;
        logic [W-1:0]       src_lq;
        lpc_flags_t         src_flags;
        logic [2:0][W-1:0]  src_s;
        logic [2:0][VW-1:0] src_v;
        logic [DW:0]        shf;
        logic [DW:0]        dif;
        logic               qbit;

        // operands come from the ports or from the previous step
        if (k == 0) begin : g_first
            assign src_vld   = in_valid;
            assign src_rem   = in_rem;
            assign src_dmag  = in_dmag;
            assign src_lq    = in_lq;
            assign src_flags = in_flags;
            assign src_s     = in_start;
            assign src_v     = in_delta;
        end else begin : g_rest
            assign src_vld   = vld_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_dmag  = dmag_reg[k-1];
            assign src_lq    = lq_reg[k-1];
            assign src_flags = flags_reg[k-1];
            assign src_s     = s_reg[k-1];
            assign src_v     = v_reg[k-1];
        end

        // shift in next dividend bit, trial subtract
        assign shf  = {src_rem, src_lq[W-1]};
        assign dif  = shf - {1'b0, src_dmag};
        assign qbit = !dif[DW];

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= src_vld;
            end
        end

        // remaining dividend bits shift out the top, quotient bits in at the bottom
        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                rem_reg[k]   <= qbit ? dif[DW-1:0] : shf[DW-1:0];
                lq_reg[k]    <= {src_lq[W-2:0], qbit};
                dmag_reg[k]  <= src_dmag;
                flags_reg[k] <= src_flags;
                s_reg[k]     <= src_s;
                v_reg[k]     <= src_v;
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign out_start = s_reg[W-1];
    assign out_delta = v_reg[W-1];
    assign out_flags = flags_reg[W-1];
    assign out_quot  = lq_reg[W-1];

    // partial remainder stays below the divisor for an in-range quotient
    `LPC_ASSERT_IMP(a_rem_below_divisor, vld_reg[W-1] && !flags_reg[W-1].par && !flags_reg[W-1].ovf, rem_reg[W-1] < dmag_reg[W-1], "divider remainder not below divisor")
    // a stalled quotient is neither lost nor altered
    `LPC_ASSERT_NXT(a_stall_holds_quotient, vld_reg[W-1] && !out_ready, vld_reg[W-1] && $stable(lq_reg[W-1]), "stalled quotient changed")

endmodule

>>> rtl/core/lpc_interp.sv
// back end: t saturation, t times delta, add to start point and saturate
// depends on lpc_pkg and line_plane_clip_point_defines.svh
`include "line_plane_clip_point_defines.svh"
module lpc_interp import lpc_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0][W-1:0]       in_start,
    input  logic [2:0][W:0]         in_delta,
    input  lpc_flags_t              in_flags,
    input  logic [W-1:0]            in_quot,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0][W-1:0]       out_clip,
    output logic                    out_par
);

    localparam int NS   = 3;
    localparam int VW   = W + 1;
    localparam int PV_W = 2 * W + 1;
    localparam int JW   = PV_W - F;
    localparam int PW   = ((JW > W) ? JW : W) + 1;
    localparam logic [W-1:0] T_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] T_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] T_HALF = {{(W-1){1'b0}}, 1'b1} << (F - 1);

    logic [NS-1:0]         vld_reg;
    logic [NS:0]           rdy;

    logic [W-1:0]          t0_reg;
    logic [2:0][W-1:0]     s0_reg;
    logic [2:0][VW-1:0]    v0_reg;
    lpc_flags_t            flags0_reg;
    logic [2:0][PV_W-1:0]  prod1_reg;
    logic [2:0][W-1:0]     s1_reg;
    logic                  par1_reg;
    logic [2:0][W-1:0]     clip2_reg;
    logic                  par2_reg;

    logic [W-1:0]          t_next;
    logic [2:0][PW-1:0]    sum_w;
    logic [2:0][W-1:0]     clip_next;
    logic [PW-W:0]         hi_bits;

    // stall chain
    assign rdy[NS] = out_ready;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end
    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 0: signed, saturated t or one half in the parallel case
    always_comb begin
        if (in_flags.par) begin
            t_next = T_HALF;
        end else if (in_flags.ovf) begin
            t_next = in_flags.neg ? T_MIN : T_MAX;
        end else if (in_flags.neg) begin
            t_next = (in_quot > T_MIN) ? T_MIN : -in_quot;
        end else begin
            t_next = in_quot[W-1] ? T_MAX : in_quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            t0_reg     <= t_next;
            s0_reg     <= in_start;
            v0_reg     <= in_delta;
            flags0_reg <= in_flags;
        end
    end

    // stage 1: t times delta per coordinate
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                prod1_reg[i] <= PV_W'($signed(t0_reg)) * PV_W'($signed(v0_reg[i]));
            end
            s1_reg   <= s0_reg;
            par1_reg <= flags0_reg.par;
        end
    end

    // stage 2: floor shift, add start point, clamp to coordinate range
    always_comb begin
        hi_bits = '0;
        for (int i = 0; i < 3; i++) begin
            sum_w[i] = PW'($signed(s1_reg[i])) + PW'($signed(prod1_reg[i][PV_W-1:F]));
            hi_bits  = sum_w[i][PW-1:W-1];
            if ((&hi_bits) || !(|hi_bits)) begin
                clip_next[i] = sum_w[i][W-1:0];
            end else begin
                clip_next[i] = sum_w[i][PW-1] ? T_MIN : T_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            clip2_reg <= clip_next;
            par2_reg  <= par1_reg;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_clip  = clip2_reg;
    assign out_par   = par2_reg;

    // t follows the quotient sign outside the parallel case
    `LPC_ASSERT_IMP(a_t_nonneg, vld_reg[0] && !flags0_reg.par && !flags0_reg.neg, !t0_reg[W-1], "t negative for positive quotient")
    `LPC_ASSERT_IMP(a_t_nonpos, vld_reg[0] && !flags0_reg.par && flags0_reg.neg, t0_reg[W-1] || (t0_reg == '0), "t positive for negative quotient")

endmodule

>>> rtl/core/line_plane_clip_point.sv
// line segment / plane clip: a pipeline built from the five front stages,
// one divider stage per quotient bit and three back stages
// throughput one transaction per cycle, the pipeline stalls only on m_tready
// synchronous active-low reset empties the pipeline and sets parallel_threshold to 66
// depends on lpc_pkg, lpc_front, lpc_div, lpc_interp
module line_plane_clip_point import lpc_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input transaction
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, normal_x, normal_y, normal_z,
    // plane_offset
    input  logic [((10*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // result transaction
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // clip_x, clip_y, clip_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
    // near_parallel
    output logic [0:0]                           m_tuser,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [APB_AW-1:0]                    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int W    = COORD_WIDTH;
    localparam int VW   = W + 1;
    localparam int DW   = 2 * W + 3;
    localparam int M_DW = ((3 * W + 7) / 8) * 8;

    logic [THR_W-1:0]     threshold_reg;
    logic [THR_W-1:0]     threshold_next;
    logic                 cfg_wr;
    logic                 sel_threshold;

    logic [2:0][W-1:0]    in_start;
    logic [2:0][W-1:0]    in_end;
    logic [2:0][W-1:0]    in_normal;
    logic [W-1:0]         in_offset;

    logic                 fr_valid;
    logic                 fr_ready;
    logic [2:0][W-1:0]    fr_start;
    logic [2:0][VW-1:0]   fr_delta;
    lpc_flags_t           fr_flags;
    logic [DW-1:0]        fr_dmag;
    logic [DW-1:0]        fr_rem;
    logic [W-1:0]         fr_lq;

    logic                 dv_valid;
    logic                 dv_ready;
    logic [2:0][W-1:0]    dv_start;
    logic [2:0][VW-1:0]   dv_delta;
    lpc_flags_t           dv_flags;
    logic [W-1:0]         dv_quot;

    logic [2:0][W-1:0]    clip;
    logic                 clip_par;

    // register port
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign sel_threshold = (paddr[APB_AW-1:2] == REG_THRESHOLD);

    always_comb begin
        threshold_next = threshold_reg;
        if (cfg_wr && sel_threshold) begin
            threshold_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THR_RESET;
        end else begin
            threshold_reg <= threshold_next;
        end
    end

    assign prdata = sel_threshold ? 32'(threshold_reg) : 32'd0;

    // unpack input fields
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign in_start[i]  = s_tdata[i*W +: W];
        assign in_end[i]    = s_tdata[(3+i)*W +: W];
        assign in_normal[i] = s_tdata[(6+i)*W +: W];
    end
    assign in_offset = s_tdata[9*W +: W];

    lpc_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_start  (in_start),
        .in_end    (in_end),
        .in_normal (in_normal),
        .in_offset (in_offset),
        .thr       (threshold_reg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_start (fr_start),
        .out_delta (fr_delta),
        .out_flags (fr_flags),
        .out_dmag  (fr_dmag),
        .out_rem   (fr_rem),
        .out_lq    (fr_lq)
    );

    lpc_div #(
        .W (W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_start  (fr_start),
        .in_delta  (fr_delta),
        .in_flags  (fr_flags),
        .in_dmag   (fr_dmag),
        .in_rem    (fr_rem),
        .in_lq     (fr_lq),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_start (dv_start),
        .out_delta (dv_delta),
        .out_flags (dv_flags),
        .out_quot  (dv_quot)
    );

    lpc_interp #(
        .W (W),
        .F (FRAC_BITS)
    ) u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_start  (dv_start),
        .in_delta  (dv_delta),
        .in_flags  (dv_flags),
        .in_quot   (dv_quot),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_clip  (clip),
        .out_par   (clip_par)
    );

    // pack result fields
    assign m_tdata    = M_DW'(clip);
    assign m_tuser[0] = clip_par;

endmodule
